// ===== rtl/core/lzd_pkg.sv =====
package lzd_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);

    localparam int         MATCH_BIT  = 7;
    localparam logic [7:0] LIT_BIAS   = 8'd1;
    localparam logic [7:0] MATCH_BIAS = 8'd3;

    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_LITERAL,
        PH_OFFSET
    } phase_t;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } ctl_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } hist_req_t;

endpackage

// ===== rtl/core/lz77_byte_token_decoder.sv =====
// Channel   Direction  Ports                                   Transaction
// s_        in         s_valid/s_ready, s_in_byte, s_first_of_ one compressed byte
//                      packet, s_last_of_packet, s_expected_size
// m_        out        m_valid/m_ready, m_out_data, m_out_count, group of up to OUT_LANES bytes
//                      m_run_end, m_packet_done, m_status
//
// Token, literal and ignored bytes are taken without entering the copy state.
// An offset byte starts a copy through the single read port of the history memory
// (match length 3..130), one byte per cycle unless a finished group waits for output.
// Reset clears control state only; the history memory is not cleared.
// Low m_ready holds the input once the output register is full, and the copy when it has a group for it.
module lz77_byte_token_decoder #(
    parameter int SIZE_BITS = 16,
    parameter int OUT_LANES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_first_of_packet,
    input  logic        s_last_of_packet,
    input  logic [15:0] s_expected_size,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_data,
    output logic [3:0]  m_out_count,
    output logic        m_run_end,
    output logic        m_packet_done,
    output logic        m_status
);

    localparam int CNT_W = $clog2(OUT_LANES + 1);
    localparam int GRP_W = 8 * OUT_LANES;
    localparam int EXT_W = SIZE_BITS + 1;

    lzd_pkg::ctl_state_t state_reg, state_next;
    lzd_pkg::phase_t     phase_reg, phase_next;

    logic [SIZE_BITS-1:0] prod_reg, prod_next;
    logic [SIZE_BITS-1:0] tgt_reg, tgt_next;
    logic [7:0]           lit_reg, lit_next;
    logic [7:0]           pend_reg, pend_next;
    logic                 err_reg, err_next;
    logic [7:0]           copy_left_reg, copy_left_next;
    logic [7:0]           off_m1_reg, off_m1_next;
    logic                 off_one_reg, off_one_next;
    logic                 last_pkt_reg, last_pkt_next;
    logic [GRP_W-1:0]     grp_data_reg, grp_data_next;
    logic [CNT_W-1:0]     grp_cnt_reg, grp_cnt_next;

    logic                 m_valid_reg, m_valid_next;
    logic [63:0]          m_data_reg, m_data_next;
    logic [3:0]           m_count_reg, m_count_next;
    logic                 m_run_end_reg, m_run_end_next;
    logic                 m_done_reg, m_done_next;
    logic                 m_status_reg, m_status_next;

    lzd_pkg::hist_req_t   hist_req;
    logic [7:0]           hist_q;

    logic                 out_free;
    logic                 copy_start;
    logic                 copy_done;

    lzd_history u_history (
        .aclk    (aclk),
        .req     (hist_req),
        .rd_data (hist_q)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lzd_pkg::ST_IDLE: begin
                if (copy_start) begin
                    state_next = lzd_pkg::ST_COPY;
                end
            end
            lzd_pkg::ST_COPY: begin
                if (copy_done) begin
                    state_next = lzd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lzd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        logic [SIZE_BITS-1:0] prod_e;
        logic [SIZE_BITS-1:0] tgt_e;
        lzd_pkg::phase_t      phase_e;
        logic [7:0]           lit_e;
        logic [7:0]           pend_e;
        logic [7:0]           len_e;
        logic                 err_e;
        logic                 emit;
        logic                 push;
        logic                 completes;
        logic [EXT_W-1:0]     off_ext;
        logic [SIZE_BITS-1:0] prod_n;
        logic [CNT_W-1:0]     cnt_inc;
        logic [GRP_W-1:0]     grp_ins;

        prod_e    = prod_reg;
        tgt_e     = tgt_reg;
        phase_e   = phase_reg;
        lit_e     = lit_reg;
        pend_e    = pend_reg;
        len_e     = '0;
        err_e     = err_reg;
        emit      = 1'b0;
        push      = 1'b0;
        completes = 1'b0;
        off_ext   = '0;
        prod_n    = prod_reg + SIZE_BITS'(1);
        cnt_inc   = grp_cnt_reg + CNT_W'(1);
        grp_ins   = grp_data_reg;

        prod_next      = prod_reg;
        tgt_next       = tgt_reg;
        phase_next     = phase_reg;
        lit_next       = lit_reg;
        pend_next      = pend_reg;
        err_next       = err_reg;
        copy_left_next = copy_left_reg;
        off_m1_next    = off_m1_reg;
        off_one_next   = off_one_reg;
        last_pkt_next  = last_pkt_reg;
        grp_data_next  = grp_data_reg;
        grp_cnt_next   = grp_cnt_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        m_count_next   = m_count_reg;
        m_run_end_next = m_run_end_reg;
        m_done_next    = m_done_reg;
        m_status_next  = m_status_reg;

        hist_req       = '0;
        copy_start     = 1'b0;
        copy_done      = 1'b0;

        case (state_reg)
            lzd_pkg::ST_IDLE: begin
                if (s_valid && out_free) begin
                    if (s_first_of_packet) begin
                        prod_e  = '0;
                        tgt_e   = SIZE_BITS'(s_expected_size);
                        phase_e = lzd_pkg::PH_TOKEN;
                        lit_e   = '0;
                        pend_e  = '0;
                        err_e   = 1'b0;
                    end
                    if (!err_e) begin
                        case (phase_e)
                            lzd_pkg::PH_TOKEN: begin
                                if (s_in_byte[lzd_pkg::MATCH_BIT]) begin
                                    pend_e  = {1'b0, s_in_byte[6:0]} + lzd_pkg::MATCH_BIAS;
                                    phase_e = lzd_pkg::PH_OFFSET;
                                end else begin
                                    len_e = {1'b0, s_in_byte[6:0]} + lzd_pkg::LIT_BIAS;
                                    if ({1'b0, prod_e} + EXT_W'(len_e) > EXT_W'(tgt_e)) begin
                                        err_e = 1'b1;
                                    end else begin
                                        lit_e   = len_e;
                                        phase_e = lzd_pkg::PH_LITERAL;
                                    end
                                end
                            end
                            lzd_pkg::PH_LITERAL: begin
                                emit             = 1'b1;
                                hist_req.wr_en   = 1'b1;
                                hist_req.wr_addr = prod_e[lzd_pkg::ADDR_W-1:0];
                                hist_req.wr_data = s_in_byte;
                                prod_e           = prod_e + SIZE_BITS'(1);
                                lit_e            = lit_e - 8'd1;
                                if (lit_e == 8'd0) begin
                                    phase_e = lzd_pkg::PH_TOKEN;
                                end
                            end
                            lzd_pkg::PH_OFFSET: begin
                                off_ext = EXT_W'(s_in_byte) + EXT_W'(1);
                                len_e   = pend_e;
                                phase_e = lzd_pkg::PH_TOKEN;
                                pend_e  = '0;
                                if (off_ext > {1'b0, prod_e} ||
                                    {1'b0, prod_e} + EXT_W'(len_e) > EXT_W'(tgt_e)) begin
                                    err_e = 1'b1;
                                end else begin
                                    copy_start       = 1'b1;
                                    copy_left_next   = len_e;
                                    off_m1_next      = s_in_byte;
                                    off_one_next     = (s_in_byte == 8'd0);
                                    last_pkt_next    = s_last_of_packet;
                                    hist_req.rd_en   = 1'b1;
                                    hist_req.rd_addr = prod_e[lzd_pkg::ADDR_W-1:0]
                                                       - s_in_byte - 8'd1;
                                end
                            end
                            default: begin
                                phase_e = lzd_pkg::PH_TOKEN;
                            end
                        endcase
                    end

                    if (s_last_of_packet && !copy_start) begin
                        if (phase_e != lzd_pkg::PH_TOKEN || prod_e != tgt_e) begin
                            err_e = 1'b1;
                        end
                    end

                    push = emit || (s_last_of_packet && !copy_start);
                    if (push) begin
                        m_valid_next   = 1'b1;
                        m_data_next    = emit ? 64'(s_in_byte) : '0;
                        m_count_next   = emit ? 4'd1 : 4'd0;
                        m_run_end_next = 1'b1;
                        m_done_next    = s_last_of_packet;
                        m_status_next  = s_last_of_packet && err_e;
                    end

                    prod_next  = prod_e;
                    tgt_next   = tgt_e;
                    phase_next = phase_e;
                    lit_next   = lit_e;
                    pend_next  = pend_e;
                    err_next   = err_e;
                end
            end

            lzd_pkg::ST_COPY: begin
                completes = (grp_cnt_reg == CNT_W'(OUT_LANES - 1)) || (copy_left_reg == 8'd1);
                if (!completes || out_free) begin
                    hist_req.wr_en   = 1'b1;
                    hist_req.wr_addr = prod_reg[lzd_pkg::ADDR_W-1:0];
                    hist_req.wr_data = hist_q;
                    hist_req.rd_en   = !off_one_reg;
                    hist_req.rd_addr = prod_reg[lzd_pkg::ADDR_W-1:0] - off_m1_reg;

                    prod_next      = prod_n;
                    copy_left_next = copy_left_reg - 8'd1;
                    copy_done      = (copy_left_reg == 8'd1);

                    for (int i = 0; i < OUT_LANES; i++) begin
                        if (CNT_W'(i) == grp_cnt_reg) begin
                            grp_ins[8*i +: 8] = hist_q;
                        end
                    end

                    if (completes) begin
                        m_valid_next   = 1'b1;
                        m_data_next    = 64'(grp_ins);
                        m_count_next   = 4'(cnt_inc);
                        m_run_end_next = copy_done;
                        m_done_next    = copy_done && last_pkt_reg;
                        m_status_next  = copy_done && last_pkt_reg && (prod_n != tgt_reg);
                        grp_data_next  = '0;
                        grp_cnt_next   = '0;
                        if (copy_done && last_pkt_reg) begin
                            err_next = (prod_n != tgt_reg);
                        end
                    end else begin
                        grp_data_next = grp_ins;
                        grp_cnt_next  = cnt_inc;
                    end
                end
            end

            default: begin
                hist_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lzd_pkg::ST_IDLE;
            phase_reg     <= lzd_pkg::PH_TOKEN;
            prod_reg      <= '0;
            tgt_reg       <= '0;
            lit_reg       <= '0;
            pend_reg      <= '0;
            err_reg       <= 1'b0;
            copy_left_reg <= '0;
            grp_data_reg  <= '0;
            grp_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            prod_reg      <= prod_next;
            tgt_reg       <= tgt_next;
            lit_reg       <= lit_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            copy_left_reg <= copy_left_next;
            grp_data_reg  <= grp_data_next;
            grp_cnt_reg   <= grp_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_m1_reg    <= off_m1_next;
        off_one_reg   <= off_one_next;
        last_pkt_reg  <= last_pkt_next;
        m_data_reg    <= m_data_next;
        m_count_reg   <= m_count_next;
        m_run_end_reg <= m_run_end_next;
        m_done_reg    <= m_done_next;
        m_status_reg  <= m_status_next;
    end

    always_comb begin
        s_ready       = (state_reg == lzd_pkg::ST_IDLE) && out_free;
        m_valid       = m_valid_reg;
        m_out_data    = m_data_reg;
        m_out_count   = m_count_reg;
        m_run_end     = m_run_end_reg;
        m_packet_done = m_done_reg;
        m_status      = m_status_reg;
    end

endmodule

// ===== rtl/core/lzd_history.sv =====
module lzd_history (
    input  logic              aclk,
    input  lzd_pkg::hist_req_t req,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [lzd_pkg::WINDOW_DEPTH];
    logic [7:0] q_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = q_reg;

endmodule
